// ----- rtl/u2l_pkg.sv -----
// Shared types and constants for the UTF-8 to Latin-1 glyph decoder.
package u2l_pkg;

    localparam int CpWidth = 21;

    localparam logic [7:0]         ReplChar   = 8'h3F;
    localparam logic [CpWidth-1:0] ReplCp     = CpWidth'(8'h3F);
    localparam logic [CpWidth-1:0] GlyphLow   = CpWidth'(16'h0020);
    localparam logic [CpWidth-1:0] GlyphHigh  = CpWidth'(16'h00FF);

    localparam logic [7:0] Lead2Mask  = 8'hE0;
    localparam logic [7:0] Lead2Code  = 8'hC0;
    localparam logic [7:0] Lead3Mask  = 8'hF0;
    localparam logic [7:0] Lead3Code  = 8'hE0;
    localparam logic [7:0] Lead4Mask  = 8'hF8;
    localparam logic [7:0] Lead4Code  = 8'hF0;
    localparam logic [1:0] ContTag    = 2'b10;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CpWidth-1:0] codepoint;
        logic [7:0]         glyph_code;
        logic               malformed;
        logic               is_control;
        logic               text_done;
    } out_item_t;

    // Result of one decode step toward the result register.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } dec_res_t;

endpackage

// ----- rtl/utf8_to_latin1_glyph_decoder_top.sv -----
// Top level: input register, decode step and result register.
// A result enters the result register after its last byte passes the input register.
// Throughput: one byte item per cycle while the result register is free or taken.
// A byte that completes no sequence advances the state and gives no result.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// decoder to idle with no bytes pending.
module utf8_to_latin1_glyph_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  u2l_pkg::in_item_t   src_item,
    output logic                res_valid,
    input  logic                res_ready,
    output u2l_pkg::out_item_t  res_item
);

    logic               stage_valid;
    logic               stage_take;
    u2l_pkg::in_item_t  stage_item;
    u2l_pkg::dec_res_t  dec;
    logic               out_free;
    logic               valid_reg;
    logic               valid_next;
    u2l_pkg::out_item_t item_reg;

    assign out_free   = !valid_reg || res_ready;
    assign stage_take = out_free;

    u2l_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .src_item    (src_item),
        .stage_valid (stage_valid),
        .stage_take  (stage_take),
        .stage_item  (stage_item)
    );

    u2l_decoder u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (stage_valid && stage_take),
        .item  (stage_item),
        .res   (dec)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = stage_valid && dec.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && stage_valid && dec.valid)
        begin
            item_reg <= dec.item;
        end
    end

    assign res_valid = valid_reg;
    assign res_item  = item_reg;

endmodule

// ----- rtl/u2l_in_stage.sv -----
// Input register stage holding one accepted byte item.
module u2l_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_ready,
    input  u2l_pkg::in_item_t  src_item,
    output logic               stage_valid,
    input  logic               stage_take,
    output u2l_pkg::in_item_t  stage_item
);

    logic              valid_reg;
    logic              valid_next;
    u2l_pkg::in_item_t item_reg;

    assign src_ready   = !valid_reg || stage_take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (src_ready)
        begin
            valid_next = src_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
        begin
            item_reg <= src_item;
        end
    end

endmodule

// ----- rtl/u2l_decoder.sv -----
// Sequence state and one-byte decode step.
module u2l_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  u2l_pkg::in_item_t  item,
    output u2l_pkg::dec_res_t  res
);

    logic [1:0]                  pending_reg;
    logic [1:0]                  pending_next;
    logic [u2l_pkg::CpWidth-1:0] partial_reg;
    logic [u2l_pkg::CpWidth-1:0] partial_next;
    logic                        bad_reg;
    logic                        bad_next;

    logic                        emit;
    logic [u2l_pkg::CpWidth-1:0] emit_cp;
    logic                        emit_bad;
    logic [u2l_pkg::CpWidth-1:0] value;
    logic [7:0]                  b;
    logic                        cont_bad;
    logic [1:0]                  pend_dec;
    logic [u2l_pkg::CpWidth-1:0] shifted;

    assign b        = item.text_byte;
    assign cont_bad = (b[7:6] != u2l_pkg::ContTag);
    assign pend_dec = pending_reg - 2'd1;
    assign shifted  = {partial_reg[u2l_pkg::CpWidth-7:0], b[5:0]};

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        bad_next     = bad_reg;
        emit         = 1'b0;
        emit_cp      = '0;
        emit_bad     = 1'b0;
        if (pending_reg == 2'd0)
        begin
            if (!b[7])
            begin
                emit    = 1'b1;
                emit_cp = u2l_pkg::CpWidth'(b);
            end
            else if ((b & u2l_pkg::Lead2Mask) == u2l_pkg::Lead2Code ||
                     (b & u2l_pkg::Lead3Mask) == u2l_pkg::Lead3Code ||
                     (b & u2l_pkg::Lead4Mask) == u2l_pkg::Lead4Code)
            begin
                if ((b & u2l_pkg::Lead2Mask) == u2l_pkg::Lead2Code)
                begin
                    pending_next = 2'd1;
                    partial_next = u2l_pkg::CpWidth'(b[4:0]);
                end
                else if ((b & u2l_pkg::Lead3Mask) == u2l_pkg::Lead3Code)
                begin
                    pending_next = 2'd2;
                    partial_next = u2l_pkg::CpWidth'(b[3:0]);
                end
                else
                begin
                    pending_next = 2'd3;
                    partial_next = u2l_pkg::CpWidth'(b[2:0]);
                end
                bad_next = 1'b0;
                if (item.end_of_text)
                begin
                    pending_next = 2'd0;
                    partial_next = '0;
                    emit         = 1'b1;
                    emit_bad     = 1'b1;
                end
            end
            else
            begin
                emit     = 1'b1;
                emit_bad = 1'b1;
            end
        end
        else
        begin
            pending_next = pend_dec;
            partial_next = shifted;
            bad_next     = bad_reg || cont_bad;
            if (pend_dec == 2'd0)
            begin
                emit         = 1'b1;
                emit_cp      = shifted;
                emit_bad     = bad_reg || cont_bad;
                partial_next = '0;
                bad_next     = 1'b0;
            end
            else if (item.end_of_text)
            begin
                emit         = 1'b1;
                emit_bad     = 1'b1;
                pending_next = 2'd0;
                partial_next = '0;
                bad_next     = 1'b0;
            end
        end
    end

    assign value = emit_bad ? u2l_pkg::ReplCp : emit_cp;

    always_comb
    begin
        res.valid           = emit;
        res.item.codepoint  = value;
        res.item.glyph_code = (value >= u2l_pkg::GlyphLow && value <= u2l_pkg::GlyphHigh)
                              ? value[7:0] : u2l_pkg::ReplChar;
        res.item.malformed  = emit_bad;
        res.item.is_control = (value < u2l_pkg::GlyphLow);
        res.item.text_done  = item.end_of_text;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            bad_reg     <= 1'b0;
        end
        else if (step)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

// ----- test/u2l_glyph_checker.sv -----
// Scoreboard for the UTF-8 to Latin-1 glyph decoder: predicts each result and checks it.
module u2l_glyph_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  logic               src_ready,
    input  u2l_pkg::in_item_t  src_item,
    input  logic               res_valid,
    input  logic               res_ready,
    input  u2l_pkg::out_item_t res_item,
    output int                 errors,
    output int                 awaiting,
    output int                 glyphs_checked,
    output int                 replacements_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    u2l_pkg::out_item_t          glyph_q[$];
    logic [1:0]                  pend_cnt;
    logic [u2l_pkg::CpWidth-1:0] acc_cp;
    logic                        cont_bad;
    int                          err_cnt = 0;
    int                          wait_cnt = 0;
    int                          glyph_cnt = 0;
    int                          repl_cnt = 0;

    assign errors               = err_cnt;
    assign awaiting             = wait_cnt;
    assign glyphs_checked       = glyph_cnt;
    assign replacements_checked = repl_cnt;

    // One decode step: advance the sequence state, queue the glyph if one completes.
    task automatic predict_glyph(input u2l_pkg::in_item_t it);
        logic [7:0]                  b;
        logic                        fire;
        logic                        bad;
        logic [u2l_pkg::CpWidth-1:0] cp;
        logic [u2l_pkg::CpWidth-1:0] value;
        u2l_pkg::out_item_t          g;
        b = it.text_byte;
        fire = 1'b0;
        bad = 1'b0;
        cp = '0;
        if (pend_cnt == 2'd0)
        begin
            if (!b[7])
            begin
                fire = 1'b1;
                cp = u2l_pkg::CpWidth'(b);
            end
            else if ((b & u2l_pkg::Lead2Mask) == u2l_pkg::Lead2Code)
            begin
                pend_cnt = 2'd1;
                acc_cp = u2l_pkg::CpWidth'(b & ~u2l_pkg::Lead2Mask);
            end
            else if ((b & u2l_pkg::Lead3Mask) == u2l_pkg::Lead3Code)
            begin
                pend_cnt = 2'd2;
                acc_cp = u2l_pkg::CpWidth'(b & ~u2l_pkg::Lead3Mask);
            end
            else if ((b & u2l_pkg::Lead4Mask) == u2l_pkg::Lead4Code)
            begin
                pend_cnt = 2'd3;
                acc_cp = u2l_pkg::CpWidth'(b & ~u2l_pkg::Lead4Mask);
            end
            else
            begin
                fire = 1'b1;
                bad = 1'b1;
            end
            if (pend_cnt != 2'd0)
            begin
                cont_bad = 1'b0;
                if (it.end_of_text)
                begin
                    // lead byte is the last byte of the text
                    pend_cnt = 2'd0;
                    acc_cp = '0;
                    fire = 1'b1;
                    bad = 1'b1;
                end
            end
        end
        else
        begin
            if (b[7:6] != u2l_pkg::ContTag)
                cont_bad = 1'b1;
            acc_cp = {acc_cp[u2l_pkg::CpWidth-7:0], b[5:0]};
            pend_cnt = pend_cnt - 2'd1;
            if (pend_cnt == 2'd0)
            begin
                fire = 1'b1;
                cp = acc_cp;
                bad = cont_bad;
                acc_cp = '0;
                cont_bad = 1'b0;
            end
            else if (it.end_of_text)
            begin
                // truncated sequence
                pend_cnt = 2'd0;
                acc_cp = '0;
                cont_bad = 1'b0;
                fire = 1'b1;
                bad = 1'b1;
            end
        end
        if (fire)
        begin
            value = bad ? u2l_pkg::ReplCp : cp;
            g.codepoint = value;
            g.glyph_code = (value >= u2l_pkg::GlyphLow && value <= u2l_pkg::GlyphHigh)
                           ? value[7:0] : u2l_pkg::ReplChar;
            g.malformed = bad;
            g.is_control = (value < u2l_pkg::GlyphLow);
            g.text_done = it.end_of_text;
            glyph_q = {glyph_q, g};
        end
    endtask

    task automatic report_field(input string field, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        err_cnt++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        u2l_pkg::out_item_t exp_g;
        if (!rst_n)
        begin
            pend_cnt = 2'd0;
            acc_cp = '0;
            cont_bad = 1'b0;
            glyph_q.delete();
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (glyph_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, got cp 0x%0h",
                             $time, res_item.codepoint);
                end
                else
                begin
                    exp_g = glyph_q.pop_front();
                    glyph_cnt++;
                    if (exp_g.malformed)
                        repl_cnt++;
                    if (res_item.codepoint !== exp_g.codepoint)
                        report_field("codepoint", 32'(exp_g.codepoint),
                                     32'(res_item.codepoint));
                    if (res_item.glyph_code !== exp_g.glyph_code)
                        report_field("glyph_code", 32'(exp_g.glyph_code),
                                     32'(res_item.glyph_code));
                    if (res_item.malformed !== exp_g.malformed)
                        report_field("malformed", 32'(exp_g.malformed),
                                     32'(res_item.malformed));
                    if (res_item.is_control !== exp_g.is_control)
                        report_field("is_control", 32'(exp_g.is_control),
                                     32'(res_item.is_control));
                    if (res_item.text_done !== exp_g.text_done)
                        report_field("text_done", 32'(exp_g.text_done),
                                     32'(res_item.text_done));
                end
            end
            if (src_valid && src_ready)
                predict_glyph(src_item);
        end
        wait_cnt = glyph_q.size();
    end

endmodule

// ----- test/utf8_to_latin1_glyph_decoder_top_test.sv -----
// Testbench top for the UTF-8 to Latin-1 glyph decoder: clock, reset, byte stimulus, verdict.
module utf8_to_latin1_glyph_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ByteTarget = 1150;
    localparam int CycleLimit = 600000;

    logic               clk;
    logic               rst_n;
    logic               src_valid;
    logic               src_ready;
    u2l_pkg::in_item_t  src_item;
    logic               res_valid;
    logic               res_ready;
    u2l_pkg::out_item_t res_item;

    int errors;
    int awaiting;
    int glyphs_checked;
    int replacements_checked;

    logic [7:0] text_q[$];
    int         bytes_sent;
    int         texts_sent;
    bit         calm_text;

    utf8_to_latin1_glyph_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    u2l_glyph_checker u_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .src_valid            (src_valid),
        .src_ready            (src_ready),
        .src_item             (src_item),
        .res_valid            (res_valid),
        .res_ready            (res_ready),
        .res_item             (res_item),
        .errors               (errors),
        .awaiting             (awaiting),
        .glyphs_checked       (glyphs_checked),
        .replacements_checked (replacements_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short idles, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 999);
        if (r < 550)
            return 0;
        if (r < 850)
            return $urandom_range(1, 2);
        if (r < 970)
            return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int                gap;
        u2l_pkg::in_item_t it;
        gap = calm_text ? 0 : idle_len();
        it.text_byte = b;
        it.end_of_text = eot;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_item <= it;
        do
            @(posedge clk);
        while (!src_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        texts_sent++;
    endtask

    // Lead byte of a len-byte sequence, then count-1 continuations; the one at
    // bad_at (if nonzero) is replaced by a byte that is not 10xxxxxx.
    task automatic add_seq(input int len, input int bad_at, input int count);
        logic [7:0] r8;
        logic [7:0] nb;
        r8 = 8'($urandom);
        case (len)
            2:       nb = {3'b110, r8[4:0]};
            3:       nb = {4'b1110, r8[3:0]};
            default: nb = {5'b11110, r8[2:0]};
        endcase
        text_q = {text_q, nb};
        for (int i = 1; i < count; i++)
        begin
            r8 = 8'($urandom);
            if (i == bad_at)
            begin
                if (r8[7:6] == u2l_pkg::ContTag)
                    r8[6] = 1'b1;
                nb = r8;
            end
            else
            begin
                nb = {u2l_pkg::ContTag, r8[5:0]};
            end
            text_q = {text_q, nb};
        end
    endtask

    task automatic add_char();
        int         r;
        int         len;
        logic [7:0] r8;
        logic [7:0] nb;
        r = $urandom_range(0, 99);
        len = $urandom_range(2, 4);
        r8 = 8'($urandom);
        if (r < 15)
        begin
            nb = {1'b0, r8[6:0]};
            text_q = {text_q, nb};
        end
        else if (r < 60)
            add_seq(len, 0, len);
        else if (r < 70)
            text_q = {text_q, r8};
        else if (r < 78)
        begin
            nb = {u2l_pkg::ContTag, r8[5:0]};
            text_q = {text_q, nb};
        end
        else if (r < 83)
        begin
            nb = {5'b11111, r8[2:0]};
            text_q = {text_q, nb};
        end
        else if (r < 91)
            add_seq(len, $urandom_range(1, len - 1), len);
        else
            add_seq(len, 0, $urandom_range(1, len - 1));
    endtask

    initial
    begin
        int n_chars;
        int len;
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_item = '0;
        bytes_sent = 0;
        texts_sent = 0;
        calm_text = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // plain bytes: NUL, DEL, literal question mark
        text_q = '{8'h00, 8'h7F, 8'h3F};
        send_text();
        // two-byte forms: Latin-1 range, top of glyph range, just beyond it
        text_q = '{8'hC2, 8'hA9, 8'hC3, 8'hBF, 8'hC4, 8'h80};
        send_text();
        // three-byte form and the largest four-byte payload
        text_q = '{8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text();
        // stray continuation, invalid leads, bad continuation
        text_q = '{8'h80, 8'hF8, 8'hFF, 8'hC3, 8'h41};
        send_text();
        // truncated sequence, lead byte at end of text
        text_q = '{8'hE2, 8'h82};
        send_text();
        text_q = '{8'hC3};
        send_text();

        while (bytes_sent < ByteTarget)
        begin
            calm_text = ($urandom_range(0, 5) == 0);
            n_chars = $urandom_range(1, 10);
            repeat (n_chars)
                add_char();
            if ($urandom_range(0, 99) < 15)
            begin
                len = $urandom_range(2, 4);
                add_seq(len, 0, $urandom_range(1, len - 1));
            end
            send_text();
        end
        src_valid <= 1'b0;

        while (awaiting != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("sent %0d bytes in %0d texts; checked %0d glyphs, %0d of them replacements",
                 bytes_sent, texts_sent, glyphs_checked, replacements_checked);
        if (errors == 0 && awaiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: random stalls, calm stretches, and long hold-offs at set byte counts.
    initial
    begin
        int stall_left;
        int calm_left;
        int hold_left;
        int hold_mark;
        stall_left = 0;
        calm_left = 0;
        hold_left = 0;
        hold_mark = 400;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_mark != 0 && bytes_sent >= hold_mark)
            begin
                hold_left = 300;
                hold_mark = (hold_mark == 400) ? 900 : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = 100;
                else if ($urandom_range(0, 2) == 0)
                    stall_left = idle_len();
            end
        end
    end

    initial
    begin
        repeat (CycleLimit) @(posedge clk);
        $display("timeout after %0d cycles", CycleLimit);
        $display("status: fail");
        $finish;
    end

endmodule
